FILE: hw/rtl/tdss_pkg.sv
// ----------------------------------------------------------------------------
// tdss_pkg
// shared types and constants of the table driven sound sequencer
// ----------------------------------------------------------------------------
package tdss_pkg;

   localparam int CHANNELS_DEF    = 8;
   localparam int TABLE_DEPTH_DEF = 512;
   localparam int RECORD_BASE_DEF = 96;

   localparam int QUEUE_DEPTH = 2;
   localparam int STEP_LIMIT  = 1024;
   localparam int GUARD_W     = 11;

   localparam logic [7:0] START_FLAG  = 8'h80;
   localparam logic [3:0] CONTROL_REG = 4'h8;

   localparam logic [2:0] MODE_TICK    = 3'd0;
   localparam logic [2:0] MODE_START   = 3'd1;
   localparam logic [2:0] MODE_STOP    = 3'd2;
   localparam logic [2:0] MODE_SILENCE = 3'd3;
   localparam logic [2:0] MODE_WRITE   = 3'd4;

   typedef enum logic [1:0] {
      KIND_TICK    = 2'd0,
      KIND_ROW     = 2'd1,
      KIND_SILENCE = 2'd2,
      KIND_WRITE   = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] sound;
      logic       keep;
      logic       zero_offset;
      logic [8:0] addr;
      logic [7:0] data;
   } cmd_type;

endpackage

FILE: hw/rtl/table_driven_sound_sequencer_core.sv
// ----------------------------------------------------------------------------
// table_driven_sound_sequencer_core
// eight channel envelope sequencer driven by a loaded sound table
//
//   channel  dir  signals                             word
//   req      in   req_tvalid/tready/tdata[31:0]/tuser  sound, keep, address, data; mode
//   rsp      out  rsp_tvalid/tready/tdata/tlast       register index, value, last
//   csr      in   csr_valid/ready/data                play active bit
//
// each request is taken up in idle; a tick then visits tick and emit for each
// idle or counting channel, with a read and a result state per table read chained
// between; start and stop visit row a and row b per loaded channel, row a alone per
// kept busy channel; table reads go at most one a cycle through the single read port
// reset clears all channel state; the table stays undefined until written
// the queue lets requests land while the sequencer waits on rsp_tready
// ----------------------------------------------------------------------------
module table_driven_sound_sequencer_core #(
   parameter int CHANNELS    = tdss_pkg::CHANNELS_DEF,
   parameter int TABLE_DEPTH = tdss_pkg::TABLE_DEPTH_DEF,
   parameter int RECORD_BASE = tdss_pkg::RECORD_BASE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // sound_number[7:0] keep_busy[8]
                                    // table_address[17:9] table_data[25:18]
   input  logic [2:0]  req_tuser,   // mode[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // register_index[3:0] register_value[11:4]
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data
);

   logic              push, q_full, pop, head_valid;
   tdss_pkg::cmd_type push_cmd, head_cmd;

   tdss_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .q_full     (q_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   tdss_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   tdss_back #(
      .CHANNELS    (CHANNELS),
      .TABLE_DEPTH (TABLE_DEPTH),
      .RECORD_BASE (RECORD_BASE)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: hw/rtl/tdss_front.sv
// ----------------------------------------------------------------------------
// tdss_front
// accepts request words, decodes the mode and holds the play register
// ----------------------------------------------------------------------------
module tdss_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [31:0]       req_tdata,
   input  logic [2:0]        req_tuser,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_data,
   input  logic              q_full,
   output logic              push,
   output tdss_pkg::cmd_type push_cmd
);

   logic       play_ff;
   logic       play_in;
   logic [2:0] mode;
   logic       known;

   assign req_tready = !q_full;
   assign csr_ready  = 1'b1;
   assign mode       = req_tuser;
   assign play_in    = (csr_valid && csr_ready) ? csr_data : play_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         play_ff <= 1'b0;
      end else begin
         play_ff <= play_in;
      end
   end

   always_comb begin
      push_cmd.sound       = req_tdata[7:0];
      push_cmd.addr        = req_tdata[17:9];
      push_cmd.data        = req_tdata[25:18];
      push_cmd.kind        = tdss_pkg::KIND_TICK;
      push_cmd.keep        = 1'b0;
      push_cmd.zero_offset = 1'b1;
      known                = 1'b1;
      case (mode)
         tdss_pkg::MODE_TICK: begin
            push_cmd.kind = tdss_pkg::KIND_TICK;
         end
         tdss_pkg::MODE_START: begin
            push_cmd.kind        = tdss_pkg::KIND_ROW;
            push_cmd.keep        = play_ff & req_tdata[8];
            push_cmd.zero_offset = !play_ff;
         end
         tdss_pkg::MODE_STOP: begin
            push_cmd.kind = tdss_pkg::KIND_ROW;
         end
         tdss_pkg::MODE_SILENCE: begin
            push_cmd.kind = tdss_pkg::KIND_SILENCE;
         end
         tdss_pkg::MODE_WRITE: begin
            push_cmd.kind = tdss_pkg::KIND_WRITE;
         end
         default: begin
            known = 1'b0;
         end
      endcase
   end

   assign push = req_tvalid && req_tready && known;

endmodule

FILE: hw/rtl/tdss_queue.sv
// ----------------------------------------------------------------------------
// tdss_queue
// short command queue between the decode side and the sequencer
// ----------------------------------------------------------------------------
module tdss_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tdss_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output tdss_pkg::cmd_type head_cmd
);

   localparam int PW = (tdss_pkg::QUEUE_DEPTH > 1) ? $clog2(tdss_pkg::QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(tdss_pkg::QUEUE_DEPTH + 1);

   tdss_pkg::cmd_type slot_ff [tdss_pkg::QUEUE_DEPTH];
   logic [PW-1:0]     wp_ff, wp_in, rp_ff, rp_in;
   logic [CW-1:0]     cnt_ff, cnt_in;

   assign full       = (cnt_ff == CW'(tdss_pkg::QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_cmd   = slot_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wp_in = (wp_ff == PW'(tdss_pkg::QUEUE_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
      end
      if (pop) begin
         rp_in = (rp_ff == PW'(tdss_pkg::QUEUE_DEPTH - 1)) ? '0 : rp_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wp_ff] <= push_cmd;
      end
   end

endmodule

FILE: hw/rtl/tdss_back.sv
// ----------------------------------------------------------------------------
// tdss_back
// sequencer: sound table, channel state, envelope stepping and write output
// ----------------------------------------------------------------------------
module tdss_back #(
   parameter int CHANNELS    = tdss_pkg::CHANNELS_DEF,
   parameter int TABLE_DEPTH = tdss_pkg::TABLE_DEPTH_DEF,
   parameter int RECORD_BASE = tdss_pkg::RECORD_BASE_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  tdss_pkg::cmd_type head_cmd,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [15:0]       rsp_tdata,
   output logic              rsp_tlast
);

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int AW   = $clog2(TABLE_DEPTH);
   localparam int SW   = AW + 1;

   typedef enum logic [15:0] {
      S_IDLE   = 16'h0001,
      S_ROW_A  = 16'h0002,
      S_ROW_B  = 16'h0004,
      S_TICK   = 16'h0008,
      S_SET2_A = 16'h0010,
      S_SET2_B = 16'h0020,
      S_LD3_A  = 16'h0040,
      S_LD3_B  = 16'h0080,
      S_LD1_A  = 16'h0100,
      S_LD1_B  = 16'h0200,
      S_SET0_A = 16'h0400,
      S_SET0_B = 16'h0800,
      S_GRP_A  = 16'h1000,
      S_GRP_B  = 16'h2000,
      S_EMIT   = 16'h4000,
      S_SIL    = 16'h8000
   } state_type;

   state_type   state_ff, state_in;
   logic [7:0]  mem [TABLE_DEPTH];
   logic [7:0]  rd_data_ff;
   logic        rd_ok_ff;
   logic        rd_en;
   logic [SW-1:0] rd_sum;
   logic [7:0]  rd_y;
   logic [1:0]  rd_k;
   logic        rd_row;
   logic [7:0]  rd_val;
   logic        wr_en;

   logic [7:0]  off_ff [CHANNELS];
   logic [7:0]  off_in [CHANNELS];
   logic [7:0]  lvl_ff [CHANNELS];
   logic [7:0]  lvl_in [CHANNELS];
   logic [7:0]  tmr_ff [CHANNELS];
   logic [7:0]  tmr_in [CHANNELS];
   logic [7:0]  stp_ff [CHANNELS];
   logic [7:0]  stp_in [CHANNELS];
   logic [7:0]  rep_ff [CHANNELS];
   logic [7:0]  rep_in [CHANNELS];
   logic [7:0]  gst_ff [CHANNELS];
   logic [7:0]  gst_in [CHANNELS];

   logic [CH_W-1:0] ch_ff, ch_in;
   logic [7:0]      y_ff, y_in;
   logic [7:0]      a_ff, a_in;
   logic [tdss_pkg::GUARD_W-1:0] guard_ff, guard_in;
   tdss_pkg::cmd_type cmd_ff, cmd_in;

   logic        out_free;
   logic        ld_out;
   logic [3:0]  out_idx;
   logic [7:0]  out_val;
   logic        out_last;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  rsp_idx_ff;
   logic [7:0]  rsp_val_ff;
   logic        rsp_last_ff;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_val_ff, rsp_idx_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rd_val     = rd_ok_ff ? rd_data_ff : 8'd0;
   assign rd_sum     = rd_row ? SW'(rd_y)
                              : SW'(RECORD_BASE) + SW'(rd_y) + SW'(rd_k);
   assign pop        = (state_ff == S_IDLE) && head_valid;
   assign wr_en      = pop && (head_cmd.kind == tdss_pkg::KIND_WRITE)
                       && (SW'(head_cmd.addr) < SW'(TABLE_DEPTH));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[AW'(head_cmd.addr)] <= head_cmd.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_sum[AW-1:0]];
         rd_ok_ff   <= (rd_sum < SW'(TABLE_DEPTH));
      end
   end

   always_comb begin
      state_in     = state_ff;
      off_in       = off_ff;
      lvl_in       = lvl_ff;
      tmr_in       = tmr_ff;
      stp_in       = stp_ff;
      rep_in       = rep_ff;
      gst_in       = gst_ff;
      ch_in        = ch_ff;
      y_in         = y_ff;
      a_in         = a_ff;
      guard_in     = guard_ff;
      cmd_in       = cmd_ff;
      rd_en        = 1'b0;
      rd_row       = 1'b0;
      rd_y         = y_ff;
      rd_k         = 2'd0;
      ld_out       = 1'b0;
      out_idx      = 4'(ch_ff);
      out_val      = lvl_ff[ch_ff];
      out_last     = (ch_ff == '0);
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      case (state_ff)
         S_IDLE: begin
            if (head_valid) begin
               cmd_in = head_cmd;
               ch_in  = CH_W'(CHANNELS - 1);
               y_in   = head_cmd.sound;
               case (head_cmd.kind)
                  tdss_pkg::KIND_TICK:    state_in = S_TICK;
                  tdss_pkg::KIND_ROW:     state_in = S_ROW_A;
                  tdss_pkg::KIND_SILENCE: state_in = S_SIL;
                  default:                state_in = S_IDLE;
               endcase
            end
         end
         S_ROW_A: begin
            if (cmd_ff.keep && off_ff[ch_ff] != 8'd0) begin
               y_in = y_ff - 8'd1;
               if (ch_ff == '0) begin
                  state_in = S_IDLE;
               end else begin
                  ch_in = ch_ff - 1'b1;
               end
            end else begin
               rd_en    = 1'b1;
               rd_row   = 1'b1;
               state_in = S_ROW_B;
            end
         end
         S_ROW_B: begin
            if (rd_val != 8'd0) begin
               rep_in[ch_ff] = tdss_pkg::START_FLAG;
               off_in[ch_ff] = cmd_ff.zero_offset ? 8'd0 : rd_val;
            end
            y_in = y_ff - 8'd1;
            if (ch_ff == '0) begin
               state_in = S_IDLE;
            end else begin
               ch_in    = ch_ff - 1'b1;
               state_in = S_ROW_A;
            end
         end
         S_TICK: begin
            guard_in = '0;
            y_in     = off_ff[ch_ff];
            state_in = S_EMIT;
            if (off_ff[ch_ff] == 8'd0) begin
               lvl_in[ch_ff] = 8'd0;
            end else if ((rep_ff[ch_ff] & tdss_pkg::START_FLAG) != 8'd0) begin
               state_in = S_GRP_A;
            end else begin
               tmr_in[ch_ff] = tmr_ff[ch_ff] - 8'd1;
               if (tmr_ff[ch_ff] == 8'd1) begin
                  stp_in[ch_ff] = stp_ff[ch_ff] - 8'd1;
                  if (stp_ff[ch_ff] != 8'd1) begin
                     state_in = S_SET2_A;
                  end else begin
                     y_in     = off_ff[ch_ff] + 8'd4;
                     state_in = S_LD3_A;
                  end
               end
            end
         end
         S_SET2_A: begin
            rd_en    = 1'b1;
            rd_k     = 2'd2;
            state_in = S_SET2_B;
         end
         S_SET2_B: begin
            a_in     = lvl_ff[ch_ff] + rd_val;
            state_in = S_SET0_A;
         end
         S_LD3_A: begin
            if (guard_ff >= tdss_pkg::GUARD_W'(tdss_pkg::STEP_LIMIT)) begin
               off_in[ch_ff] = 8'd0;
               lvl_in[ch_ff] = 8'd0;
               state_in      = S_EMIT;
            end else begin
               guard_in      = guard_ff + 1'b1;
               off_in[ch_ff] = y_ff;
               rd_en         = 1'b1;
               rd_k          = 2'd3;
               state_in      = S_LD3_B;
            end
         end
         S_LD3_B: begin
            stp_in[ch_ff] = rd_val;
            state_in      = S_LD1_A;
         end
         S_LD1_A: begin
            rd_en    = 1'b1;
            rd_k     = 2'd1;
            state_in = S_LD1_B;
         end
         S_LD1_B: begin
            a_in     = rd_val;
            state_in = S_SET0_A;
         end
         S_SET0_A: begin
            if (guard_ff >= tdss_pkg::GUARD_W'(tdss_pkg::STEP_LIMIT)) begin
               off_in[ch_ff] = 8'd0;
               lvl_in[ch_ff] = 8'd0;
               state_in      = S_EMIT;
            end else begin
               guard_in      = guard_ff + 1'b1;
               lvl_in[ch_ff] = a_ff;
               rd_en         = 1'b1;
               rd_k          = 2'd0;
               state_in      = S_SET0_B;
            end
         end
         S_SET0_B: begin
            tmr_in[ch_ff] = rd_val;
            if (rd_val != 8'd0) begin
               state_in = S_EMIT;
            end else begin
               rep_in[ch_ff] = rep_ff[ch_ff] - 8'd1;
               if (rep_ff[ch_ff] != 8'd1) begin
                  y_in     = gst_ff[ch_ff];
                  state_in = S_LD3_A;
               end else begin
                  y_in = off_ff[ch_ff] + 8'd1;
                  if (off_ff[ch_ff] == 8'hff) begin
                     off_in[ch_ff] = 8'd0;
                     lvl_in[ch_ff] = 8'd0;
                     state_in      = S_EMIT;
                  end else begin
                     state_in = S_GRP_A;
                  end
               end
            end
         end
         S_GRP_A: begin
            if (guard_ff >= tdss_pkg::GUARD_W'(tdss_pkg::STEP_LIMIT)) begin
               off_in[ch_ff] = 8'd0;
               lvl_in[ch_ff] = 8'd0;
               state_in      = S_EMIT;
            end else begin
               guard_in = guard_ff + 1'b1;
               rd_en    = 1'b1;
               rd_k     = 2'd0;
               state_in = S_GRP_B;
            end
         end
         S_GRP_B: begin
            if (rd_val == 8'd0) begin
               off_in[ch_ff] = 8'd0;
               lvl_in[ch_ff] = 8'd0;
               state_in      = S_EMIT;
            end else begin
               rep_in[ch_ff] = rd_val;
               y_in          = y_ff + 8'd1;
               gst_in[ch_ff] = y_ff + 8'd1;
               state_in      = S_LD3_A;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               ld_out       = 1'b1;
               rsp_valid_in = 1'b1;
               if (ch_ff == '0) begin
                  state_in = S_IDLE;
               end else begin
                  ch_in    = ch_ff - 1'b1;
                  state_in = S_TICK;
               end
            end
         end
         S_SIL: begin
            out_idx  = tdss_pkg::CONTROL_REG;
            out_val  = 8'd0;
            out_last = 1'b1;
            if (out_free) begin
               ld_out       = 1'b1;
               rsp_valid_in = 1'b1;
               for (int i = 0; i < CHANNELS; i++) begin
                  off_in[i] = 8'd0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            off_ff[i] <= 8'd0;
            lvl_ff[i] <= 8'd0;
            tmr_ff[i] <= 8'd0;
            stp_ff[i] <= 8'd0;
            rep_ff[i] <= 8'd0;
            gst_ff[i] <= 8'd0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         off_ff       <= off_in;
         lvl_ff       <= lvl_in;
         tmr_ff       <= tmr_in;
         stp_ff       <= stp_in;
         rep_ff       <= rep_in;
         gst_ff       <= gst_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff    <= ch_in;
      y_ff     <= y_in;
      a_ff     <= a_in;
      guard_ff <= guard_in;
      cmd_ff   <= cmd_in;
      if (ld_out) begin
         rsp_idx_ff  <= out_idx;
         rsp_val_ff  <= out_val;
         rsp_last_ff <= out_last;
      end
   end

endmodule

FILE: bench/sound_write_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sound_write_checker
// watches the request, result and csr channels of the sound sequencer core,
// keeps its own copy of the table and channel state, predicts the register
// writes of every accepted request and compares each result word against them
// ----------------------------------------------------------------------------
module sound_write_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // sound_number[7:0] keep_busy[8]
                                    // table_address[17:9] table_data[25:18]
   input  logic [2:0]  req_tuser,   // mode[2:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // register_index[3:0] register_value[11:4]
   input  logic        rsp_tlast,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_data,
   output int          mismatch_count,
   output int          writes_pending,
   output int          writes_checked
);

   localparam int NCH       = 8;
   localparam int TBL_DEPTH = 512;
   localparam int REC_BASE  = 96;

   localparam int ST_LOAD  = 0;
   localparam int ST_SET   = 1;
   localparam int ST_GROUP = 2;

   typedef struct packed {
      logic [3:0] index;
      logic [7:0] value;
      logic       last;
   } reg_write_type;

   reg_write_type expected_writes[$];

   logic       play_active;
   logic [7:0] sound_table [TBL_DEPTH];
   logic [7:0] rec_offset  [NCH];
   logic [7:0] level       [NCH];
   logic [7:0] timer       [NCH];
   logic [7:0] steps       [NCH];
   logic [7:0] grp_repeats [NCH];
   logic [7:0] grp_start   [NCH];

   function automatic logic [7:0] table_byte(int a);
      return (a < TBL_DEPTH) ? sound_table[a] : 8'd0;
   endfunction

   function automatic logic [7:0] rec_byte(int k, logic [7:0] y);
      return table_byte(REC_BASE + int'(y) + k);
   endfunction

   task automatic step_channel(int c);
      logic [7:0] y;
      logic [7:0] a;
      int st;
      int guard;
      y = rec_offset[c];
      a = 8'd0;
      guard = 0;
      st = ST_LOAD;
      if (y == 8'd0) begin
         level[c] = 8'd0;
         return;
      end
      if ((grp_repeats[c] & tdss_pkg::START_FLAG) != 8'd0) begin
         st = ST_GROUP;
      end else begin
         timer[c] = timer[c] - 8'd1;
         if (timer[c] != 8'd0) return;
         steps[c] = steps[c] - 8'd1;
         if (steps[c] != 8'd0) begin
            a = level[c] + rec_byte(2, y);
            st = ST_SET;
         end else begin
            y = y + 8'd4;
            st = ST_LOAD;
         end
      end
      forever begin
         guard++;
         if (guard > tdss_pkg::STEP_LIMIT) begin
            rec_offset[c] = 8'd0;
            level[c] = 8'd0;
            return;
         end
         case (st)
            ST_LOAD: begin
               rec_offset[c] = y;
               steps[c] = rec_byte(3, y);
               a = rec_byte(1, y);
               st = ST_SET;
            end
            ST_SET: begin
               level[c] = a;
               timer[c] = rec_byte(0, y);
               if (timer[c] != 8'd0) return;
               y = grp_start[c];
               grp_repeats[c] = grp_repeats[c] - 8'd1;
               if (grp_repeats[c] != 8'd0) begin
                  st = ST_LOAD;
               end else begin
                  y = rec_offset[c] + 8'd1;
                  if (y == 8'd0) begin
                     rec_offset[c] = 8'd0;
                     level[c] = 8'd0;
                     return;
                  end
                  st = ST_GROUP;
               end
            end
            default: begin
               a = rec_byte(0, y);
               if (a == 8'd0) begin
                  rec_offset[c] = 8'd0;
                  level[c] = 8'd0;
                  return;
               end
               grp_repeats[c] = a;
               y = y + 8'd1;
               grp_start[c] = y;
               st = ST_LOAD;
            end
         endcase
      end
   endtask

   task automatic load_sound_row(logic [7:0] y, logic keep, logic off);
      logic [7:0] a;
      for (int x = NCH - 1; x >= 0; x--) begin
         if (!(keep && rec_offset[x] != 8'd0)) begin
            a = table_byte(int'(y));
            if (a != 8'd0) begin
               grp_repeats[x] = tdss_pkg::START_FLAG;
               rec_offset[x] = off ? 8'd0 : a;
            end
         end
         y = y - 8'd1;
      end
   endtask

   task automatic predict_request(logic [2:0] mode, logic [31:0] w);
      reg_write_type wr;
      case (mode)
         tdss_pkg::MODE_TICK: begin
            for (int k = 0; k < NCH; k++) begin
               step_channel(NCH - 1 - k);
               wr.index = 4'(NCH - 1 - k);
               wr.value = level[NCH - 1 - k];
               wr.last  = (k == NCH - 1);
               expected_writes.push_back(wr);
            end
         end
         tdss_pkg::MODE_START:
            load_sound_row(w[7:0], play_active ? w[8] : 1'b0, !play_active);
         tdss_pkg::MODE_STOP: load_sound_row(w[7:0], 1'b0, 1'b1);
         tdss_pkg::MODE_SILENCE: begin
            for (int c = 0; c < NCH; c++) rec_offset[c] = 8'd0;
            wr.index = tdss_pkg::CONTROL_REG;
            wr.value = 8'd0;
            wr.last  = 1'b1;
            expected_writes.push_back(wr);
         end
         tdss_pkg::MODE_WRITE: begin
            if (int'(w[17:9]) < TBL_DEPTH) sound_table[w[17:9]] = w[25:18];
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      reg_write_type exp_w;
      if (reset) begin
         play_active <= 1'b0;
         for (int c = 0; c < NCH; c++) begin
            rec_offset[c]  = 8'd0;
            level[c]       = 8'd0;
            timer[c]       = 8'd0;
            steps[c]       = 8'd0;
            grp_repeats[c] = 8'd0;
            grp_start[c]   = 8'd0;
         end
         expected_writes.delete();
      end else begin
         if (csr_valid && csr_ready) play_active <= csr_data;
         if (rsp_tvalid && rsp_tready) begin
            writes_checked++;
            if (expected_writes.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected word: index %0d value %0h last %0b",
                           rsp_tdata[3:0], rsp_tdata[11:4], rsp_tlast);
            end else begin
               exp_w = expected_writes.pop_front();
               if (exp_w.index !== rsp_tdata[3:0] || exp_w.value !== rsp_tdata[11:4] ||
                   exp_w.last !== rsp_tlast) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: expected index %0d value %0h last %0b, got %0d %0h %0b",
                              exp_w.index, exp_w.value, exp_w.last,
                              rsp_tdata[3:0], rsp_tdata[11:4], rsp_tlast);
               end
            end
         end
         if (req_tvalid && req_tready) predict_request(req_tuser, req_tdata);
      end
      writes_pending = expected_writes.size();
   end

endmodule

FILE: bench/table_driven_sound_sequencer_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// table_driven_sound_sequencer_core_test
// loads a well formed sound table, then runs directed and random ticks, starts,
// stops, silences, table writes and unknown modes under both play settings, with
// bursty requests and a stalling result side; a separate checker
// predicts the writes
module table_driven_sound_sequencer_core_test;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int IMG_TOP     = 355;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_data = 1'b0;

   int mismatch_count, writes_pending, writes_checked;
   int cycles = 0;
   int burst_left = 0;
   int n_ticks = 0, n_starts = 0, n_other = 0;
   int stall_mode = 0;
   logic [7:0] table_img [IMG_TOP];

   table_driven_sound_sequencer_core i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   sound_write_checker i_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .mismatch_count(mismatch_count), .writes_pending(writes_pending),
      .writes_checked(writes_checked)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver stall pattern, picked at random among four modes
   always @(posedge clock) begin
      if (cycles % 256 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 9) < 7);
         2: rsp_tready <= (cycles % 5 != 0);
         default: rsp_tready <= ((cycles / 16) % 3 == 0);
      endcase
   end

   // mode in the top three bits, data word below
   function automatic logic [34:0] req_word(logic [2:0] mode, logic [7:0] snd, logic keep,
                                            logic [8:0] addr, logic [7:0] data);
      return {mode, 6'b000000, data, addr, keep, snd};
   endfunction

   function automatic logic [34:0] noisy_word(logic [2:0] mode, logic [7:0] snd, logic keep);
      return req_word(mode, snd, keep, 9'($urandom), 8'($urandom));
   endfunction

   task automatic send_word(logic [34:0] w);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= w[34:32];
      req_tdata  <= w[31:0];
      do @(posedge clock); while (!req_tready);
      if (w[34:32] == tdss_pkg::MODE_TICK) n_ticks++;
      else if (w[34:32] == tdss_pkg::MODE_START) n_starts++;
      else n_other++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (writes_pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_play(logic v);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] env_offset();
      return 8'(1 + 16 * $urandom_range(0, 15));
   endfunction

   task automatic build_table();
      int y;
      for (int a = 0; a < IMG_TOP; a++) table_img[a] = 8'd0;
      for (int a = 0; a < 96; a++)
         table_img[a] = ($urandom_range(0, 1) == 0) ? env_offset() : 8'd0;
      for (int e = 0; e < 16; e++) begin
         y = 96 + 1 + 16 * e;
         // group count, two records, then a zero timer ends the group
         table_img[y] = (e == 5) ? 8'h82 : 8'($urandom_range(1, 3));
         for (int r = 0; r < 2; r++) begin
            table_img[y + 1 + 4 * r] = 8'($urandom_range(1, 3));
            table_img[y + 2 + 4 * r] = 8'($urandom);
            table_img[y + 3 + 4 * r] = 8'($urandom);
            table_img[y + 4 + 4 * r] = 8'($urandom_range(1, 3));
         end
      end
   endtask

   task automatic random_item();
      int pick;
      logic [7:0] row;
      pick = $urandom_range(0, 99);
      row  = 8'(8 * $urandom_range(0, 11) + 7);
      if (pick < 45)
         send_word(noisy_word(tdss_pkg::MODE_TICK, 8'($urandom), 1'($urandom)));
      else if (pick < 67)
         send_word(noisy_word(tdss_pkg::MODE_START, row, 1'($urandom)));
      else if (pick < 72)
         send_word(noisy_word(tdss_pkg::MODE_START, 8'($urandom), 1'($urandom)));
      else if (pick < 80)
         send_word(noisy_word(tdss_pkg::MODE_STOP,
                              ($urandom_range(0, 3) == 0) ? 8'($urandom) : row,
                              1'($urandom)));
      else if (pick < 85)
         send_word(noisy_word(tdss_pkg::MODE_SILENCE, 8'($urandom), 1'($urandom)));
      else if (pick < 92)
         send_word(req_word(tdss_pkg::MODE_WRITE, 8'($urandom), 1'($urandom),
                            9'($urandom_range(0, 95)),
                            ($urandom_range(0, 2) == 0) ? 8'd0 : env_offset()));
      else if (pick < 96)
         send_word(req_word(tdss_pkg::MODE_WRITE, 8'($urandom), 1'($urandom),
                            9'($urandom_range(IMG_TOP, 511)), 8'($urandom)));
      else
         send_word(noisy_word(3'($urandom_range(5, 7)), 8'($urandom), 1'($urandom)));
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      build_table();
      write_play(1'b0);
      for (int a = 0; a < IMG_TOP; a++)
         send_word(req_word(tdss_pkg::MODE_WRITE, 8'($urandom), 1'($urandom), 9'(a),
                            table_img[a]));
      send_word(req_word(tdss_pkg::MODE_WRITE, 8'hff, 1'b1, 9'd511, 8'hff));
      send_word(req_word(tdss_pkg::MODE_WRITE, 8'h00, 1'b0, 9'd400, 8'h00));

      // play inactive: starts behave as stops
      send_word(noisy_word(tdss_pkg::MODE_START, 8'd7, 1'b0));
      send_word(noisy_word(tdss_pkg::MODE_TICK, 8'd0, 1'b0));
      write_play(1'b1);
      send_word(noisy_word(tdss_pkg::MODE_START, 8'd7, 1'b0));
      repeat (3) send_word(noisy_word(tdss_pkg::MODE_TICK, 8'hff, 1'b1));
      send_word(noisy_word(tdss_pkg::MODE_START, 8'd15, 1'b1));
      send_word(noisy_word(tdss_pkg::MODE_TICK, 8'd0, 1'b0));
      send_word(noisy_word(tdss_pkg::MODE_START, 8'd95, 1'b0));
      send_word(noisy_word(tdss_pkg::MODE_TICK, 8'd0, 1'b0));
      send_word(noisy_word(tdss_pkg::MODE_STOP, 8'd7, 1'b1));
      send_word(noisy_word(tdss_pkg::MODE_TICK, 8'd0, 1'b0));
      send_word(noisy_word(tdss_pkg::MODE_START, 8'd255, 1'b0));
      send_word(noisy_word(tdss_pkg::MODE_TICK, 8'd0, 1'b0));
      send_word(noisy_word(tdss_pkg::MODE_SILENCE, 8'd0, 1'b0));
      send_word(noisy_word(tdss_pkg::MODE_TICK, 8'd0, 1'b0));
      send_word(noisy_word(3'd5, 8'd0, 1'b0));
      send_word(noisy_word(3'd6, 8'd0, 1'b0));
      send_word(noisy_word(3'd7, 8'd0, 1'b0));
      send_word(noisy_word(tdss_pkg::MODE_TICK, 8'd0, 1'b0));

      repeat (40) random_item();
      wait_idle();
      repeat (15) random_item();
      write_play(1'b0);
      repeat (15) random_item();
      write_play(1'b1);
      repeat (22) random_item();
      wait_idle();

      $display("covered %0d ticks, %0d starts, %0d other requests; %0d writes checked",
               n_ticks, n_starts, n_other, writes_checked);
      if (mismatch_count == 0 && writes_pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches, %0d writes never seen", mismatch_count, writes_pending);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/tdss_pkg.sv
hw/rtl/tdss_front.sv
hw/rtl/tdss_queue.sv
hw/rtl/tdss_back.sv
hw/rtl/table_driven_sound_sequencer_core.sv
bench/sound_write_checker.sv
bench/table_driven_sound_sequencer_core_test.sv
